// ===== hdl/iplog_pkg.sv =====
// Shared types, constants and microcode table of the integer power and floor log core.
`timescale 1ns / 1ps

package iplog_pkg;

  // Operand and answer width
  localparam int DW    = 32;
  localparam int CntW  = $clog2(DW);
  localparam int StepW = 4;

  // Operation codes
  localparam logic OP_POWER = 1'b0;
  localparam logic OP_LOG   = 1'b1;

  // Microcode step addresses
  localparam logic [StepW-1:0] S_START    = 4'd0;
  localparam logic [StepW-1:0] S_PW_ZERO  = 4'd1;
  localparam logic [StepW-1:0] S_PW_NEG   = 4'd2;
  localparam logic [StepW-1:0] S_PW_LOOP  = 4'd3;
  localparam logic [StepW-1:0] S_PW_SQR   = 4'd4;
  localparam logic [StepW-1:0] S_RET_ACC  = 4'd5;
  localparam logic [StepW-1:0] S_RET_ZERO = 4'd6;
  localparam logic [StepW-1:0] S_LG_CHK   = 4'd7;
  localparam logic [StepW-1:0] S_LG_MUL   = 4'd8;
  localparam logic [StepW-1:0] S_LG_STEP  = 4'd9;
  localparam logic [StepW-1:0] S_RET_E    = 4'd10;
  localparam logic [StepW-1:0] S_RET_NEG1 = 4'd11;

  // Datapath actions
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_MUL_ACC_BIT,
    ACT_SQUARE,
    ACT_LOG_MUL,
    ACT_LOG_STEP,
    ACT_RET_ACC,
    ACT_RET_ZERO,
    ACT_RET_NEG1,
    ACT_RET_E
  } act_e;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_OP_LOG,
    COND_EXP_ZERO,
    COND_EXP_NEG,
    COND_CNT_MORE,
    COND_LOG_BAD,
    COND_PROD_LE
  } cond_e;

  // One control word of the program
  typedef struct packed {
    act_e              act;
    cond_e             cond;
    logic [StepW-1:0]  target;
    logic              last;
  } uword_t;

  // Status flags from the datapath
  typedef struct packed {
    logic op_log;
    logic exp_zero;
    logic exp_neg;
    logic cnt_more;
    logic log_bad;
    logic prod_le;
  } flags_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    logic busy;
    logic fire;
    logic taken;
    act_e act;
  } ctrl_t;

  // Return steps leave the program and fill the answer register
  function automatic logic is_ret(act_e a);
    return (a == ACT_RET_ACC) || (a == ACT_RET_ZERO) ||
           (a == ACT_RET_NEG1) || (a == ACT_RET_E);
  endfunction

  // Microcode program
  function automatic uword_t urom(logic [StepW-1:0] step);
    uword_t w;
    w = '{act: ACT_RET_NEG1, cond: COND_NEVER, target: S_START, last: 1'b1};
    case (step)
      S_START:    w = '{act: ACT_NONE,        cond: COND_OP_LOG,   target: S_LG_CHK,   last: 1'b0};
      S_PW_ZERO:  w = '{act: ACT_NONE,        cond: COND_EXP_ZERO, target: S_RET_ACC,  last: 1'b0};
      S_PW_NEG:   w = '{act: ACT_NONE,        cond: COND_EXP_NEG,  target: S_RET_ZERO, last: 1'b0};
      S_PW_LOOP:  w = '{act: ACT_MUL_ACC_BIT, cond: COND_NEVER,    target: S_START,    last: 1'b0};
      S_PW_SQR:   w = '{act: ACT_SQUARE,      cond: COND_CNT_MORE, target: S_PW_LOOP,  last: 1'b0};
      S_RET_ACC:  w = '{act: ACT_RET_ACC,     cond: COND_NEVER,    target: S_START,    last: 1'b1};
      S_RET_ZERO: w = '{act: ACT_RET_ZERO,    cond: COND_NEVER,    target: S_START,    last: 1'b1};
      S_LG_CHK:   w = '{act: ACT_NONE,        cond: COND_LOG_BAD,  target: S_RET_NEG1, last: 1'b0};
      S_LG_MUL:   w = '{act: ACT_LOG_MUL,     cond: COND_NEVER,    target: S_START,    last: 1'b0};
      S_LG_STEP:  w = '{act: ACT_LOG_STEP,    cond: COND_PROD_LE,  target: S_LG_MUL,   last: 1'b0};
      S_RET_E:    w = '{act: ACT_RET_E,       cond: COND_NEVER,    target: S_START,    last: 1'b1};
      S_RET_NEG1: w = '{act: ACT_RET_NEG1,    cond: COND_NEVER,    target: S_START,    last: 1'b1};
      default:    w = '{act: ACT_RET_NEG1,    cond: COND_NEVER,    target: S_START,    last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/iplog_seq.sv =====
// Microcode sequencer: step counter, program table and conditional jumps.
`timescale 1ns / 1ps

module iplog_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            hold_i,
  input  iplog_pkg::flags_t flags_i,
  output iplog_pkg::ctrl_t  ctrl_o
);
  import iplog_pkg::*;

  logic             busy_q, busy_d;
  logic [StepW-1:0] step_q, step_d;
  uword_t           word;
  logic             taken;
  logic             fire;

  // Fetch the current control word
  assign word = urom(step_q);

  // Evaluate the jump condition
  always_comb begin
    case (word.cond)
      COND_NEVER:    taken = 1'b0;
      COND_OP_LOG:   taken = flags_i.op_log;
      COND_EXP_ZERO: taken = flags_i.exp_zero;
      COND_EXP_NEG:  taken = flags_i.exp_neg;
      COND_CNT_MORE: taken = flags_i.cnt_more;
      COND_LOG_BAD:  taken = flags_i.log_bad;
      COND_PROD_LE:  taken = flags_i.prod_le;
      default:       taken = 1'b0;
    endcase
  end

  assign fire = busy_q && !hold_i;

  // Advance, jump, hold or leave the program
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        step_d = S_START;
      end
    end else if (fire) begin
      if (word.last) begin
        busy_d = 1'b0;
      end else if (taken) begin
        step_d = word.target;
      end else begin
        step_d = step_q + StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= S_START;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  assign ctrl_o = '{busy: busy_q, fire: fire, taken: taken, act: word.act};

endmodule

// ===== hdl/integer_power_and_floor_log_core.sv =====
// Top level of the integer power and floor log core: handshakes and datapath.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------
//   in      | input     | in_valid_i/in_ready_o | opcode_i, first_operand_i, second_operand_i
//   out     | output    | out_valid_o/out_ready_i | answer_o
//
// Power runs 32 square-and-multiply rounds, each a multiply step and a square step on the
// shared 32x32 multiplier; a zero exponent or a negative one returns without a round.
// Floor log runs one multiply and one compare per round until the product passes the number,
// or returns -1 for an invalid pair. One request is in flight at a time; a new one transfers
// the cycle after the answer is written to the output register, even while that answer waits.
// Reset clears the sequencer and the output valid; a stalled answer holds the program.
`timescale 1ns / 1ps

module integer_power_and_floor_log_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           opcode_i,
  input  logic signed [iplog_pkg::DW-1:0] first_operand_i,
  input  logic signed [iplog_pkg::DW-1:0] second_operand_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [iplog_pkg::DW-1:0] answer_o
);
  import iplog_pkg::*;

  logic              op_q;
  logic [DW-1:0]     a_q;
  logic [DW-1:0]     b_q;
  logic [DW-1:0]     acc_q;
  logic [CntW-1:0]   e_q;
  logic [CntW-1:0]   cnt_q;
  logic [2*DW-1:0]   prod_q;
  logic              out_valid_q;
  logic [DW-1:0]     answer_q;

  logic              start;
  logic              hold;
  flags_t            flags;
  ctrl_t             ctrl;
  logic [DW-1:0]     mul_x;
  logic [2*DW-1:0]   mul_p;

  // Accept a request only when no program runs
  assign in_ready_o = !ctrl.busy;
  assign start      = in_valid_i && in_ready_o;

  // Hold a return step while the output register is full
  assign hold = is_ret(ctrl.act) && out_valid_q && !out_ready_i;

  // Status flags for the jump conditions
  assign flags.op_log   = (op_q == OP_LOG);
  assign flags.exp_zero = (b_q == '0);
  assign flags.exp_neg  = b_q[DW-1];
  assign flags.cnt_more = (cnt_q != CntW'(DW - 1));
  assign flags.log_bad  = a_q[DW-1] || (a_q < DW'(2)) || b_q[DW-1] || (b_q == '0);
  assign flags.prod_le  = (prod_q <= {{DW{1'b0}}, b_q});

  iplog_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .hold_i  (hold),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  // Shared multiplier: square the base or multiply the accumulator by it
  assign mul_x = (ctrl.act == ACT_SQUARE) ? a_q : acc_q;
  assign mul_p = {{DW{1'b0}}, mul_x} * {{DW{1'b0}}, a_q};

  // Load operands on transfer, then execute the current control word
  always_ff @(posedge clk_i) begin
    if (start) begin
      op_q  <= opcode_i;
      a_q   <= first_operand_i;
      b_q   <= second_operand_i;
      acc_q <= DW'(1);
      e_q   <= '0;
      cnt_q <= '0;
    end else if (ctrl.fire) begin
      case (ctrl.act)
        ACT_MUL_ACC_BIT: begin
          if (b_q[0]) begin
            acc_q <= mul_p[DW-1:0];
          end
        end
        ACT_SQUARE: begin
          a_q   <= mul_p[DW-1:0];
          b_q   <= b_q >> 1;
          cnt_q <= cnt_q + CntW'(1);
        end
        ACT_LOG_MUL: begin
          prod_q <= mul_p;
        end
        ACT_LOG_STEP: begin
          if (ctrl.taken) begin
            acc_q <= prod_q[DW-1:0];
            e_q   <= e_q + CntW'(1);
          end
        end
        ACT_RET_ACC:  answer_q <= acc_q;
        ACT_RET_ZERO: answer_q <= '0;
        ACT_RET_NEG1: answer_q <= '1;
        ACT_RET_E:    answer_q <= {{(DW-CntW){1'b0}}, e_q};
        default: begin
        end
      endcase
    end
  end

  // Output valid: set by a return step, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.fire && is_ret(ctrl.act)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign answer_o    = answer_q;

endmodule

// ===== hdl/iplog_chk.sv =====
// Port-level assertions of the integer power and floor log core, with their bind.
`timescale 1ns / 1ps

module iplog_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           opcode_i,
  input logic signed [iplog_pkg::DW-1:0] first_operand_i,
  input logic signed [iplog_pkg::DW-1:0] second_operand_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic signed [iplog_pkg::DW-1:0] answer_o
);
  import iplog_pkg::*;

  // Hold a stalled answer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(answer_o))
    else $error("stalled answer changed or dropped");

  // Stay busy after a transfer in through at least a start, a check and a return step
  a_busy_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("request finished too early");

  // A new answer appears only at the end of a running request
  a_out_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("answer without a running request");

endmodule

bind integer_power_and_floor_log_core iplog_chk u_iplog_chk (.*);

// ===== tb/tb_integer_power_and_floor_log_core.sv =====
// Self-checking testbench for the integer power and floor log core.
`timescale 1ns / 1ps

module tb_integer_power_and_floor_log_core;
  import iplog_pkg::*;

  typedef logic signed [DW-1:0] word_t;

  logic  clk_i            = 1'b0;
  logic  rst_ni           = 1'b0;
  logic  in_valid_i       = 1'b0;
  logic  opcode_i         = OP_POWER;
  word_t first_operand_i  = '0;
  word_t second_operand_i = '0;
  logic  out_ready_i      = 1'b0;
  logic  in_ready_o;
  logic  out_valid_o;
  word_t answer_o;

  // Answers still owed by the core, oldest first
  word_t expected_answers[$];

  int errors          = 0;
  int answers_checked = 0;
  int power_requests  = 0;
  int log_requests    = 0;

  // Idling controls shared with the receiver
  bit sender_idle     = 1'b1;
  bit sink_idle       = 1'b1;
  int hold_off_cycles = 0;

  integer_power_and_floor_log_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .answer_o         (answer_o)
  );

  always #5 clk_i = ~clk_i;

  // Square-and-multiply over every exponent bit, wrapping at the data width
  function automatic word_t predict_power(word_t base, word_t expo);
    logic [DW-1:0] acc;
    logic [DW-1:0] sq;
    int            i;
    acc = 1;
    sq  = base;
    if (expo == 0) return 1;
    if (expo < 0) return 0;
    for (i = 0; i < DW; i++) begin
      if (expo[i]) acc = acc * sq;
      sq = sq * sq;
    end
    return acc;
  endfunction

  // Largest e with base**e <= num; the product never passes num, so no overflow
  function automatic word_t predict_floor_log(word_t base, word_t num);
    logic [2*DW-1:0] prod;
    logic [2*DW-1:0] limit;
    logic [DW-1:0]   e;
    if (base < 2 || num < 1) return -1;
    limit = num / base;
    prod  = 1;
    e     = 0;
    while (prod <= limit) begin
      prod = prod * base;
      e++;
    end
    return e;
  endfunction

  // Check each answer transfer, then record the prediction for each request transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_answers.size() == 0) begin
        $error("answer %0d arrived with no request pending", answer_o);
        errors++;
      end else begin
        if (answer_o !== expected_answers[0]) begin
          $error("answer mismatch: expected %0d, actual %0d", expected_answers[0], answer_o);
          errors++;
        end
        void'(expected_answers.pop_front());
        answers_checked++;
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (opcode_i == OP_LOG) begin
        expected_answers.push_back(predict_floor_log(first_operand_i, second_operand_i));
        log_requests++;
      end else begin
        expected_answers.push_back(predict_power(first_operand_i, second_operand_i));
        power_requests++;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles != 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 19);
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offer one request and hold it until the transfer; valid stays high afterwards
  task automatic send_request(logic op, word_t a, word_t b);
    int gap;
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    opcode_i         <= op;
    first_operand_i  <= a;
    second_operand_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every answer owed has come back
  task automatic wait_for_answers();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_answers.size() != 0) @(posedge clk_i);
  endtask

  function automatic word_t pick_extreme();
    case ($urandom_range(0, 5))
      0:       return {1'b1, {(DW-1){1'b0}}};
      1:       return {1'b0, {(DW-1){1'b1}}};
      2:       return 0;
      3:       return 1;
      4:       return -1;
      default: return 2;
    endcase
  endfunction

  // Mostly meaningful operands, with full-range and extreme values mixed in
  task automatic send_random_request();
    word_t a;
    word_t b;
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 3))
        0:       a = $urandom;
        1:       a = $signed($urandom_range(0, 18)) - 9;
        2:       a = pick_extreme();
        default: a = $urandom_range(2, 300);
      endcase
      case ($urandom_range(0, 4))
        0:       b = $urandom;
        1:       b = $urandom | {1'b1, {(DW-1){1'b0}}};
        2:       b = pick_extreme();
        default: b = $urandom_range(0, 40);
      endcase
      send_request(OP_POWER, a, b);
    end else begin
      case ($urandom_range(0, 9))
        0:       a = $urandom;
        1:       a = pick_extreme();
        2:       a = $signed($urandom_range(0, 4)) - 2;
        default: a = $urandom_range(2, 20);
      endcase
      case ($urandom_range(0, 5))
        0:       b = $urandom;
        1:       b = pick_extreme();
        2:       b = $urandom_range(1, 1000);
        default: b = $urandom >> 1;
      endcase
      send_request(OP_LOG, a, b);
    end
  endtask

  // Zero and negative exponents, wrapping products and operand extremes
  task automatic test_power_special_cases();
    send_request(OP_POWER, 0, 0);
    send_request(OP_POWER, 32'sh8000_0000, 0);
    send_request(OP_POWER, 5, -1);
    send_request(OP_POWER, 0, 32'sh8000_0000);
    send_request(OP_POWER, 7, 1);
    send_request(OP_POWER, 2, 31);
    send_request(OP_POWER, 2, 32);
    send_request(OP_POWER, 3, 40);
    send_request(OP_POWER, -1, 32'sh7fff_ffff);
    send_request(OP_POWER, -2, 31);
    send_request(OP_POWER, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_request(OP_POWER, 32'sh8000_0000, 2);
    wait_for_answers();
  endtask

  // Invalid bases and numbers, a number of one, and exact powers of the base
  task automatic test_log_special_cases();
    send_request(OP_LOG, 1, 100);
    send_request(OP_LOG, 0, 100);
    send_request(OP_LOG, 32'sh8000_0000, 100);
    send_request(OP_LOG, 2, 0);
    send_request(OP_LOG, 2, -1);
    send_request(OP_LOG, 10, 32'sh8000_0000);
    send_request(OP_LOG, 2, 1);
    send_request(OP_LOG, 32'sh7fff_ffff, 1);
    send_request(OP_LOG, 2, 32'sh7fff_ffff);
    send_request(OP_LOG, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_request(OP_LOG, 3, 80);
    send_request(OP_LOG, 3, 81);
    send_request(OP_LOG, 10, 9);
    wait_for_answers();
  endtask

  // Stall the receiver for a long stretch while requests keep coming
  task automatic test_output_hold_off();
    int i;
    sender_idle     = 1'b0;
    hold_off_cycles = 400;
    for (i = 0; i < 12; i++) send_random_request();
    wait_for_answers();
    sender_idle = 1'b1;
  endtask

  // Random traffic in chunks, with idling switched on and off per chunk
  task automatic test_random_traffic(int chunks);
    int c;
    int i;
    for (c = 0; c < chunks; c++) begin
      sender_idle = ($urandom_range(0, 3) != 0);
      sink_idle   = ($urandom_range(0, 3) != 0);
      for (i = 0; i < 100; i++) send_random_request();
      if (c == chunks / 2) wait_for_answers();
    end
  endtask

  // Back-to-back traffic with neither side idling
  task automatic test_steady_stream(int count);
    int i;
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    for (i = 0; i < count; i++) send_random_request();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_power_special_cases();
    test_log_special_cases();
    test_output_hold_off();
    test_random_traffic(10);
    test_steady_stream(150);
    wait_for_answers();
    repeat (100) @(posedge clk_i);
    $display("Checked %0d answers from %0d power and %0d floor log requests,",
             answers_checked, power_requests, log_requests);
    $display("covering special cases, random operands, idling and a long output stall.");
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
